FILE: sv/lru_kv_pkg.sv
// Shared types, constants and sizes for the LRU key/value cache.
package lru_kv_pkg;

  // Number of entries in the store.
  localparam int ENTRIES = 16;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = SLOT_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Capacity register.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Action codes.
  localparam logic ACTION_GET = 1'b0;
  localparam logic ACTION_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic signed [31:0] READ_MISS = -32'sd1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } ctrl_cmd_t;

endpackage

FILE: sv/lru_kv_ctrl.sv
// Controller state machine sequencing accept, lookup and update of one item.
module lru_kv_ctrl import lru_kv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  // State register and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE);
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result follows exactly one update step.
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_UPDATE)
    else $error("result strobe without a preceding update");

  // An accepted beat always walks lookup then update.
  a_accept_sequence: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_LOOKUP) ##1 (state == ST_UPDATE))
    else $error("accepted beat did not pass through lookup and update");

endmodule

FILE: sv/lru_kv_datapath.sv
// Datapath: key/value store, associative compare, recency ranks and result register.
module lru_kv_datapath import lru_kv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  input  item_t            item,
  input  logic             cfg_valid,
  input  logic [CAP_W-1:0] cfg_data,
  output result_t          result
);

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Storage.
  logic [ENTRIES-1:0]             entry_valid;
  logic signed [31:0]             entry_key   [ENTRIES];
  logic signed [31:0]             entry_value [ENTRIES];
  logic [RANK_W-1:0]              recency_rank [ENTRIES];
  logic [CNT_W-1:0]               used_count;
  logic [CAP_W-1:0]               capacity;

  // Item and lookup outcome registers.
  item_t             item_q;
  logic              hit_q;
  logic              full_q;
  logic [SLOT_W-1:0] slot_q;

  // Lookup logic.
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lru_hit;
  logic               any_match;
  logic [SLOT_W-1:0]  hit_slot;
  logic [SLOT_W-1:0]  lru_slot;
  logic [SLOT_W-1:0]  free_slot;
  logic [CMP_W-1:0]   eff_cap;
  logic               full;

  // Update logic.
  logic [CNT_W-1:0]   touch_rank;

  // Capacity register, written through its own channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Capacity clamped to the range one to the number of entries.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
    full = CMP_W'(used_count) >= eff_cap;
  end

  // Associative compare; the oldest valid entry holds rank used_count minus one.
  always_comb begin
    hit_slot  = '0;
    lru_slot  = '0;
    free_slot = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      match[j]   = entry_valid[j] && (entry_key[j] == item_q.key);
      lru_hit[j] = entry_valid[j] &&
                   ((CNT_W'(recency_rank[j]) + CNT_W'(1)) == used_count);
    end
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (match[j])        hit_slot  = SLOT_W'(j);
      if (lru_hit[j])      lru_slot  = SLOT_W'(j);
      if (!entry_valid[j]) free_slot = SLOT_W'(j);
    end
    any_match = |match;
  end

  // Capture the item, then the lookup outcome.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.lookup) begin
      hit_q  <= any_match;
      full_q <= full;
      if (any_match) begin
        slot_q <= hit_slot;
      end else if (full) begin
        slot_q <= lru_slot;
      end else begin
        slot_q <= free_slot;
      end
    end
  end

  // Rank of the touched entry before the touch; a fresh entry counts as oldest plus one.
  always_comb begin
    if (hit_q || full_q) begin
      touch_rank = CNT_W'(recency_rank[slot_q]);
    end else begin
      touch_rank = used_count;
    end
  end

  // Control state of the store.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      used_count  <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        recency_rank[j] <= '0;
      end
    end else if (cmd.update && (hit_q || item_q.action == ACTION_PUT)) begin
      // Age every valid entry more recent than the touched one.
      for (int j = 0; j < ENTRIES; j++) begin
        if (SLOT_W'(j) == slot_q) begin
          recency_rank[j] <= '0;
        end else if (entry_valid[j] && (CNT_W'(recency_rank[j]) < touch_rank)) begin
          recency_rank[j] <= recency_rank[j] + RANK_W'(1);
        end
      end
      if (!hit_q) begin
        entry_valid[slot_q] <= 1'b1;
        if (!full_q) begin
          used_count <= used_count + CNT_W'(1);
        end
      end
    end
  end

  // Key and value writes.
  always_ff @(posedge clk) begin
    if (cmd.update && item_q.action == ACTION_PUT) begin
      entry_value[slot_q] <= item_q.value;
      if (!hit_q) begin
        entry_key[slot_q] <= item_q.key;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.hit         <= hit_q;
      result.evicted     <= 1'b0;
      result.evicted_key <= '0;
      if (item_q.action == ACTION_GET) begin
        result.read_value <= hit_q ? entry_value[slot_q] : READ_MISS;
      end else begin
        result.read_value <= '0;
        if (!hit_q && full_q) begin
          result.evicted     <= 1'b1;
          result.evicted_key <= entry_key[slot_q];
        end
      end
    end
  end

  // The fill count tracks the valid bits.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == used_count)
    else $error("fill count disagrees with valid bits");

  // At most one entry holds any given key.
  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> $onehot0(match))
    else $error("duplicate key in store");

  // A full store always has an oldest entry to evict.
  a_lru_exists: assert property (@(posedge clk) disable iff (rst)
    (cmd.lookup && full) |-> $onehot(lru_hit))
    else $error("no unique least recently used entry");

endmodule

FILE: sv/lru_key_value_cache.sv
// Top level of the LRU key/value cache: controller plus datapath.
//
//  channel   ports                        handshake
//  --------  ---------------------------  ------------------------------
//  input     start, busy, item            beat taken when start & !busy
//  result    done, result                 one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready,        beat taken when valid & ready
//            cfg_data
//
// Each item steps through accept, associative lookup over all entries,
// then the store and recency rank update; done rises in the cycle after the
// update and a new item can be accepted in that same cycle.
// Reset is synchronous and active high; it empties the store and sets
// capacity to 16. cfg_ready is always high. The receiver cannot stall.
module lru_key_value_cache import lru_kv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output logic             done,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequencer.
  lru_kv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Store and update logic.
  lru_kv_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
